FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the censor filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/acf_pkg.sv
// ---------------------------------------------------------------------------
// acf_pkg
// Sizes, codes and helper functions of the censor filter.
// ---------------------------------------------------------------------------
package acf_pkg;
   localparam int MAX_NODES = 1024;
   localparam int ALPHABET  = 26;
   localparam int MAX_TEXT  = 4096;

   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int CNT_W   = NODE_W + 1;
   localparam int SYM_W   = 5;
   localparam int SLOT_N  = MAX_NODES * ALPHABET;
   localparam int SLOT_W  = $clog2(SLOT_N);
   localparam int TIDX_W  = $clog2(MAX_TEXT);
   localparam int TEXT_W  = TIDX_W + 1;
   localparam int LEN_W   = 11;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [SYM_W-1:0]  sym_type;
   typedef logic [1:0]        status_type;
   typedef logic [1:0]        reqkind_type;

   // Request kinds.
   localparam reqkind_type REQ_PATTERN = 2'd0;
   localparam reqkind_type REQ_TEXT    = 2'd1;
   localparam reqkind_type REQ_READ    = 2'd2;

   // Result status codes.
   localparam status_type STAT_OK         = 2'd0;
   localparam status_type STAT_TRIE_FULL  = 2'd1;
   localparam status_type STAT_STACK_FULL = 2'd2;
   localparam status_type STAT_EMPTY      = 2'd3;

   // Goto table address of one node and letter.
   function automatic logic [SLOT_W-1:0] slot_addr(input node_type node, input sym_type c);
      return SLOT_W'(int'(node) * ALPHABET + int'(c));
   endfunction
endpackage

FILE: hdl/acf_if.sv
// ---------------------------------------------------------------------------
// acf channel interfaces
// Valid/ready channels for request and response items.
// ---------------------------------------------------------------------------
interface acf_req_if;
   import acf_pkg::*;
   logic        valid;
   logic        ready;
   reqkind_type req_type;
   sym_type     symbol;
   logic        pattern_end;
   modport source (output valid, req_type, symbol, pattern_end, input ready);
   modport sink   (input valid, req_type, symbol, pattern_end, output ready);
endinterface

interface acf_rsp_if;
   import acf_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   sym_type    out_symbol;
   logic       out_last;
   modport source (output valid, status, out_symbol, out_last, input ready);
   modport sink   (input valid, status, out_symbol, out_last, output ready);
endinterface

FILE: hdl/aho_corasick_censor_filter.sv
// ---------------------------------------------------------------------------
// aho_corasick_censor_filter
// Trie build, automaton construction and censoring text stack.
// ---------------------------------------------------------------------------
//  Channel  Dir  Contents
//  req_ch   in   req_type, symbol, pattern_end
//  rsp_ch   out  status, out_symbol, out_last
//
// A pattern symbol looks up its goto edge and, when it creates a node, clears
// that node's row. A text symbol runs the build after new patterns first: the
// root row, then each trie node in breadth-first order, then the push steps.
// After reset a pass clears the root row before items are accepted.
// A stalled result holds the block in its final state until it is taken.
`include "assert_macros.svh"

module aho_corasick_censor_filter (
   input logic clock,
   input logic reset,
   acf_req_if.sink   req_ch,
   acf_rsp_if.source rsp_ch
);
   import acf_pkg::*;

   localparam logic [4:0] S_CLR    = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_INS0   = 5'd2;
   localparam logic [4:0] S_INS1   = 5'd3;
   localparam logic [4:0] S_TX0    = 5'd4;
   localparam logic [4:0] S_TX1    = 5'd5;
   localparam logic [4:0] S_TX2    = 5'd6;
   localparam logic [4:0] S_TX3    = 5'd7;
   localparam logic [4:0] S_BR0    = 5'd8;
   localparam logic [4:0] S_BR1    = 5'd9;
   localparam logic [4:0] S_BPOP   = 5'd10;
   localparam logic [4:0] S_BFAIL  = 5'd11;
   localparam logic [4:0] S_BFAIL2 = 5'd12;
   localparam logic [4:0] S_BVIA   = 5'd13;
   localparam logic [4:0] S_BEDGE  = 5'd14;
   localparam logic [4:0] S_BWR    = 5'd15;
   localparam logic [4:0] S_RD0    = 5'd16;
   localparam logic [4:0] S_RD1    = 5'd17;
   localparam logic [4:0] S_DONE   = 5'd18;

   localparam sym_type LAST_SYM = SYM_W'(ALPHABET - 1);

   // Memories and their ports.
   logic [NODE_W:0]   goto_mem [SLOT_N];
   logic [LEN_W-1:0]  ml_mem   [MAX_NODES];
   node_type          fail_mem [MAX_NODES];
   node_type          queue_mem[MAX_NODES];
   sym_type           tsym_mem [MAX_TEXT];
   node_type          tst_mem  [MAX_TEXT];

   logic [NODE_W:0]   goto_rdata_ff, goto_wdata;
   logic [SLOT_W-1:0] goto_raddr, goto_waddr;
   logic              goto_we;
   logic [LEN_W-1:0]  ml_rdata_ff, ml_wdata;
   node_type          ml_raddr, ml_waddr;
   logic              ml_we;
   node_type          fail_rdata_ff, fail_raddr, fail_waddr, fail_wdata;
   logic              fail_we;
   node_type          q_rdata_ff, q_raddr, q_waddr, q_wdata;
   logic              q_we;
   sym_type           tsym_rdata_ff;
   node_type          tst_rdata_ff, tst_wdata;
   logic [TIDX_W-1:0] tsym_raddr, tst_raddr, tx_waddr;
   logic              tx_we;

   // Control and datapath registers.
   logic [4:0]        state_ff, state_in;
   logic              init_ff, init_in;
   sym_type           sym_ff, sym_in, chr_ff, chr_in;
   logic              end_ff, end_in;
   node_type          node_count_ff, node_count_in, cursor_ff, cursor_in;
   logic [LEN_W-1:0]  depth_ff, depth_in;
   logic              needs_build_ff, needs_build_in;
   logic [TEXT_W-1:0] top_ff, top_in, rc_ff, rc_in;
   logic [CNT_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   node_type          row_ff, row_in, p_ff, p_in, f_ff, f_in, via_ff, via_in;
   status_type        res_status_ff, res_status_in;
   sym_type           res_sym_ff, res_sym_in;
   logic              res_last_ff, res_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   sym_type           rsp_sym_ff, rsp_sym_in;
   logic              rsp_last_ff, rsp_last_in;

   // Helper values of the state logic.
   node_type          next_node, below;
   logic [LEN_W-1:0]  depth_next;
   logic [TEXT_W-1:0] pop_len, new_top;

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.out_symbol = rsp_sym_ff;
   assign rsp_ch.out_last   = rsp_last_ff;

   // Memory arrays: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (goto_we) goto_mem[goto_waddr] <= goto_wdata;
      goto_rdata_ff <= goto_mem[goto_raddr];
      if (ml_we) ml_mem[ml_waddr] <= ml_wdata;
      ml_rdata_ff <= ml_mem[ml_raddr];
      if (fail_we) fail_mem[fail_waddr] <= fail_wdata;
      fail_rdata_ff <= fail_mem[fail_raddr];
      if (q_we) queue_mem[q_waddr] <= q_wdata;
      q_rdata_ff <= queue_mem[q_raddr];
      if (tx_we) begin
         tsym_mem[tx_waddr] <= sym_ff;
         tst_mem[tx_waddr]  <= tst_wdata;
      end
      tsym_rdata_ff <= tsym_mem[tsym_raddr];
      tst_rdata_ff  <= tst_mem[tst_raddr];
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;        init_in = init_ff;
      sym_in = sym_ff;            chr_in = chr_ff;          end_in = end_ff;
      node_count_in = node_count_ff;   cursor_in = cursor_ff;
      depth_in = depth_ff;        needs_build_in = needs_build_ff;
      top_in = top_ff;            rc_in = rc_ff;
      head_in = head_ff;          tail_in = tail_ff;
      row_in = row_ff;            p_in = p_ff;   f_in = f_ff;   via_in = via_ff;
      res_status_in = res_status_ff;  res_sym_in = res_sym_ff;  res_last_in = res_last_ff;
      rsp_status_in = rsp_status_ff;  rsp_sym_in = rsp_sym_ff;  rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      goto_raddr = '0;  goto_we = 1'b0;  goto_waddr = '0;  goto_wdata = '0;
      ml_raddr = '0;    ml_we = 1'b0;    ml_waddr = '0;    ml_wdata = '0;
      fail_raddr = '0;  fail_we = 1'b0;  fail_waddr = '0;  fail_wdata = '0;
      q_raddr = '0;     q_we = 1'b0;     q_waddr = '0;     q_wdata = '0;
      tsym_raddr = '0;  tst_raddr = '0;  tx_we = 1'b0;     tx_waddr = '0;
      tst_wdata = '0;

      next_node  = goto_rdata_ff[NODE_W-1:0];
      below      = (top_ff == '0) ? '0 : tst_rdata_ff;
      depth_next = (depth_ff == '1) ? depth_ff : depth_ff + 1'b1;
      pop_len    = (TEXT_W'(ml_rdata_ff) > top_ff) ? top_ff : TEXT_W'(ml_rdata_ff);
      new_top    = top_ff - pop_len;

      case (state_ff)
         // Zero one goto row: the root after reset, a fresh node otherwise.
         S_CLR: begin
            goto_we    = 1'b1;
            goto_waddr = slot_addr(row_ff, chr_ff);
            goto_wdata = '0;
            if (init_ff) begin
               ml_we    = 1'b1;
               ml_waddr = '0;
               ml_wdata = '0;
            end
            if (chr_ff == LAST_SYM) begin
               chr_in   = '0;
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_DONE;
            end else begin
               chr_in = chr_ff + 1'b1;
            end
         end

         // Take an item and dispatch on its kind.
         S_IDLE: begin
            if (req_ch.valid) begin
               sym_in        = req_ch.symbol;
               end_in        = req_ch.pattern_end;
               res_status_in = STAT_OK;
               res_sym_in    = '0;
               res_last_in   = 1'b0;
               state_in      = S_DONE;
               case (req_ch.req_type)
                  REQ_PATTERN: begin
                     if (int'(req_ch.symbol) < ALPHABET) state_in = S_INS0;
                  end
                  REQ_TEXT: begin
                     if (int'(req_ch.symbol) < ALPHABET) begin
                        if (top_ff == TEXT_W'(MAX_TEXT)) begin
                           res_status_in = STAT_STACK_FULL;
                        end else if (needs_build_ff) begin
                           chr_in   = '0;
                           head_in  = '0;
                           tail_in  = '0;
                           state_in = S_BR0;
                        end else begin
                           state_in = S_TX0;
                        end
                     end
                  end
                  REQ_READ: begin
                     if (rc_ff >= top_ff) res_status_in = STAT_EMPTY;
                     else state_in = S_RD0;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // Trie insert: look up the edge, then follow or create it.
         S_INS0: begin
            goto_raddr = slot_addr(cursor_ff, sym_ff);
            state_in   = S_INS1;
         end
         S_INS1: begin
            state_in = S_DONE;
            if (!goto_rdata_ff[NODE_W] &&
                ({1'b0, node_count_ff} + 1'b1 >= CNT_W'(MAX_NODES))) begin
               res_status_in = STAT_TRIE_FULL;
            end else begin
               if (!goto_rdata_ff[NODE_W]) begin
                  next_node     = node_count_ff + 1'b1;
                  node_count_in = next_node;
                  goto_we       = 1'b1;
                  goto_waddr    = slot_addr(cursor_ff, sym_ff);
                  goto_wdata    = {1'b1, next_node};
                  row_in        = next_node;
                  chr_in        = '0;
                  state_in      = S_CLR;
               end
               ml_we          = !goto_rdata_ff[NODE_W] || end_ff;
               ml_waddr       = next_node;
               ml_wdata       = end_ff ? depth_next : '0;
               needs_build_in = 1'b1;
               cursor_in      = end_ff ? '0 : next_node;
               depth_in       = end_ff ? '0 : depth_next;
            end
         end

         // Text push: state below, goto step, store, match length pop.
         S_TX0: begin
            tst_raddr = TIDX_W'(top_ff - 1'b1);
            state_in  = S_TX1;
         end
         S_TX1: begin
            goto_raddr = slot_addr(below, sym_ff);
            state_in   = S_TX2;
         end
         S_TX2: begin
            tx_we     = 1'b1;
            tx_waddr  = top_ff[TIDX_W-1:0];
            tst_wdata = goto_rdata_ff[NODE_W-1:0];
            ml_raddr  = goto_rdata_ff[NODE_W-1:0];
            top_in    = top_ff + 1'b1;
            state_in  = S_TX3;
         end
         S_TX3: begin
            top_in = new_top;
            if (rc_ff > new_top) rc_in = new_top;
            state_in = S_DONE;
         end

         // Build, root row: children get the root as fail link.
         S_BR0: begin
            goto_raddr = slot_addr('0, chr_ff);
            state_in   = S_BR1;
         end
         S_BR1: begin
            if (goto_rdata_ff[NODE_W]) begin
               fail_we    = 1'b1;
               fail_waddr = goto_rdata_ff[NODE_W-1:0];
               fail_wdata = '0;
               if (tail_ff < CNT_W'(MAX_NODES)) begin
                  q_we    = 1'b1;
                  q_waddr = tail_ff[NODE_W-1:0];
                  q_wdata = goto_rdata_ff[NODE_W-1:0];
                  tail_in = tail_ff + 1'b1;
               end
            end else begin
               goto_we    = 1'b1;
               goto_waddr = slot_addr('0, chr_ff);
               goto_wdata = '0;
            end
            chr_in   = (chr_ff == LAST_SYM) ? '0 : chr_ff + 1'b1;
            state_in = (chr_ff == LAST_SYM) ? S_BPOP : S_BR0;
         end

         // Build, breadth-first: take a node and fetch its fail link.
         S_BPOP: begin
            if (head_ff < tail_ff) begin
               q_raddr  = head_ff[NODE_W-1:0];
               head_in  = head_ff + 1'b1;
               state_in = S_BFAIL;
            end else begin
               needs_build_in = 1'b0;
               state_in       = S_TX0;
            end
         end
         S_BFAIL: begin
            p_in       = q_rdata_ff;
            fail_raddr = q_rdata_ff;
            state_in   = S_BFAIL2;
         end
         S_BFAIL2: begin
            f_in     = fail_rdata_ff;
            chr_in   = '0;
            state_in = S_BVIA;
         end

         // Per letter: transition of the fail node, then the node's own entry.
         S_BVIA: begin
            goto_raddr = slot_addr(f_ff, chr_ff);
            state_in   = S_BEDGE;
         end
         S_BEDGE: begin
            via_in     = goto_rdata_ff[NODE_W-1:0];
            goto_raddr = slot_addr(p_ff, chr_ff);
            state_in   = S_BWR;
         end
         S_BWR: begin
            if (goto_rdata_ff[NODE_W]) begin
               fail_we    = 1'b1;
               fail_waddr = goto_rdata_ff[NODE_W-1:0];
               fail_wdata = via_ff;
               if (tail_ff < CNT_W'(MAX_NODES)) begin
                  q_we    = 1'b1;
                  q_waddr = tail_ff[NODE_W-1:0];
                  q_wdata = goto_rdata_ff[NODE_W-1:0];
                  tail_in = tail_ff + 1'b1;
               end
            end else begin
               goto_we    = 1'b1;
               goto_waddr = slot_addr(p_ff, chr_ff);
               goto_wdata = {1'b0, via_ff};
            end
            chr_in   = (chr_ff == LAST_SYM) ? '0 : chr_ff + 1'b1;
            state_in = (chr_ff == LAST_SYM) ? S_BPOP : S_BVIA;
         end

         // Read the next surviving symbol.
         S_RD0: begin
            tsym_raddr = rc_ff[TIDX_W-1:0];
            state_in   = S_RD1;
         end
         S_RD1: begin
            res_sym_in  = tsym_rdata_ff;
            rc_in       = rc_ff + 1'b1;
            res_last_in = (rc_ff + 1'b1 == top_ff);
            state_in    = S_DONE;
         end

         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_sym_in    = res_sym_ff;
               rsp_last_in   = res_last_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLR;
         init_ff        <= 1'b1;
         chr_ff         <= '0;
         row_ff         <= '0;
         node_count_ff  <= '0;
         cursor_ff      <= '0;
         depth_ff       <= '0;
         needs_build_ff <= 1'b0;
         top_ff         <= '0;
         rc_ff          <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         init_ff        <= init_in;
         chr_ff         <= chr_in;
         row_ff         <= row_in;
         node_count_ff  <= node_count_in;
         cursor_ff      <= cursor_in;
         depth_ff       <= depth_in;
         needs_build_ff <= needs_build_in;
         top_ff         <= top_in;
         rc_ff          <= rc_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      end_ff        <= end_in;
      p_ff          <= p_in;
      f_ff          <= f_in;
      via_ff        <= via_in;
      res_status_ff <= res_status_in;
      res_sym_ff    <= res_sym_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Checks.
   `AST_IMPL(a_read_in_stack, clock, reset, 1'b1, rc_ff <= top_ff)
   `AST_IMPL(a_queue_order, clock, reset, 1'b1, head_ff <= tail_ff)
   `AST_NEXT(a_done_delivers, clock, reset, (state_ff == S_DONE) && !rsp_valid_ff, rsp_valid_ff && (state_ff == S_IDLE))
endmodule

FILE: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the censor filter. A shadow automaton predicts
// every response; directed, random, back-pressure and overflow tests run
// in turn, with random idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import acf_pkg::*;

   localparam reqkind_type REQ_NONE = 2'd3;
   localparam int IDLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      status_type status;
      sym_type    sym;
      logic       last;
   } resp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   acf_req_if req_ch ();
   acf_rsp_if rsp_ch ();

   aho_corasick_censor_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow automaton state.
   logic [NODE_W-1:0] sh_goto [SLOT_N];
   bit                sh_edge [SLOT_N];
   logic [NODE_W-1:0] sh_fail [MAX_NODES];
   logic [LEN_W-1:0]  sh_mlen [MAX_NODES];
   logic [NODE_W-1:0] sh_queue [MAX_NODES];
   sym_type           sh_text [MAX_TEXT];
   logic [NODE_W-1:0] sh_tstate [MAX_TEXT];
   int unsigned       sh_nodes, sh_cursor, sh_depth, sh_top, sh_rd;
   bit                sh_dirty;

   resp_type awaited_resps[$];
   int    errors = 0;
   bit    calm = 1'b0;
   bit    hold_rsp = 1'b0;

   function automatic int unsigned slot_of(int unsigned n, int unsigned c);
      return (n % MAX_NODES) * ALPHABET + (c % ALPHABET);
   endfunction

   // Breadth-first fail links and full goto table.
   function automatic void rebuild_automaton();
      int unsigned head, tail, p, f, ch, e;
      logic [NODE_W-1:0] via;
      head = 0;
      tail = 0;
      for (int c = 0; c < ALPHABET; c++) begin
         e = slot_of(0, c);
         if (sh_edge[e]) begin
            ch = sh_goto[e];
            sh_fail[ch] = '0;
            if (tail < MAX_NODES) begin
               sh_queue[tail] = node_type'(ch);
               tail++;
            end
         end else begin
            sh_goto[e] = '0;
         end
      end
      while (head < tail) begin
         p = sh_queue[head];
         head++;
         f = sh_fail[p];
         for (int c = 0; c < ALPHABET; c++) begin
            e = slot_of(p, c);
            via = sh_goto[slot_of(f, c)];
            if (sh_edge[e]) begin
               ch = sh_goto[e];
               sh_fail[ch] = via;
               if (tail < MAX_NODES) begin
                  sh_queue[tail] = node_type'(ch);
                  tail++;
               end
            end else begin
               sh_goto[e] = via;
            end
         end
      end
      sh_dirty = 1'b0;
   endfunction

   function automatic status_type trie_insert(int unsigned sym, bit fin);
      int unsigned e, nxt;
      e = slot_of(sh_cursor, sym);
      if (sh_edge[e]) begin
         nxt = sh_goto[e];
      end else begin
         if (sh_nodes + 1 >= MAX_NODES) return STAT_TRIE_FULL;
         sh_nodes++;
         nxt = sh_nodes;
         sh_goto[e] = node_type'(nxt);
         sh_edge[e] = 1'b1;
         for (int c = 0; c < ALPHABET; c++) begin
            sh_goto[slot_of(nxt, c)] = '0;
            sh_edge[slot_of(nxt, c)] = 1'b0;
         end
         sh_fail[nxt] = '0;
         sh_mlen[nxt] = '0;
      end
      sh_cursor = nxt;
      if (sh_depth < 2047) sh_depth++;
      sh_dirty = 1'b1;
      if (fin) begin
         sh_mlen[nxt] = sh_depth[LEN_W-1:0];
         sh_cursor = 0;
         sh_depth = 0;
      end
      return STAT_OK;
   endfunction

   function automatic status_type text_push(int unsigned sym);
      int unsigned below, st, len;
      if (sh_top >= MAX_TEXT) return STAT_STACK_FULL;
      if (sh_dirty) rebuild_automaton();
      below = (sh_top != 0) ? sh_tstate[sh_top-1] : 0;
      st = sh_goto[slot_of(below, sym)];
      sh_text[sh_top] = sym_type'(sym);
      sh_tstate[sh_top] = node_type'(st);
      sh_top++;
      len = sh_mlen[st];
      if (len != 0) begin
         if (len > sh_top) len = sh_top;
         sh_top -= len;
         if (sh_rd > sh_top) sh_rd = sh_top;
      end
      return STAT_OK;
   endfunction

   // Expected response of one accepted request item.
   function automatic resp_type predict_censor(reqkind_type kind, sym_type sym, logic fin);
      resp_type r;
      r = '0;
      r.status = STAT_OK;
      if (kind == REQ_PATTERN) begin
         if (sym < ALPHABET) r.status = trie_insert(sym, fin);
      end else if (kind == REQ_TEXT) begin
         if (sym < ALPHABET) r.status = text_push(sym);
      end else if (kind == REQ_READ) begin
         if (sh_rd >= sh_top) begin
            r.status = STAT_EMPTY;
         end else begin
            r.sym = sh_text[sh_rd];
            sh_rd++;
            r.last = (sh_rd == sh_top);
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // Sends one request item, optionally after a random idle burst.
   task automatic send_item(input reqkind_type kind, input int unsigned sym, input bit fin);
      resp_type want;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= kind;
      req_ch.symbol      <= sym_type'(sym);
      req_ch.pattern_end <= fin;
      do @(posedge clock); while (!req_ch.ready);
      want = predict_censor(kind, sym_type'(sym), fin);
      awaited_resps = {awaited_resps, want};
   endtask

   task automatic send_pattern(input int unsigned letters[$]);
      foreach (letters[i]) send_item(REQ_PATTERN, letters[i], i == letters.size() - 1);
   endtask

   // Response checker.
   always @(posedge clock) begin
      resp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_resps.size() == 0) begin
            report_mismatch("unexpected response", rsp_ch.status, -1);
         end else begin
            want = awaited_resps.pop_front();
            if (rsp_ch.status != want.status)
               report_mismatch("status", rsp_ch.status, want.status);
            if (rsp_ch.out_symbol != want.sym)
               report_mismatch("out_symbol", rsp_ch.out_symbol, want.sym);
            if (rsp_ch.out_last != want.last)
               report_mismatch("out_last", rsp_ch.out_last, want.last);
         end
      end
   end

   // Response ready with random stall bursts and one long hold.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any handshake.
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // Empty reads, unused request kind and out-of-alphabet symbols, then small
   // patterns with matches, pops and patterns added after text.
   task automatic test_directed();
      send_item(REQ_READ, 0, 1'b0);
      send_item(REQ_NONE, 31, 1'b1);
      send_item(REQ_PATTERN, 31, 1'b1);
      send_item(REQ_TEXT, 26, 1'b1);
      send_pattern('{0, 1});
      send_pattern('{1, 2, 2});
      send_item(REQ_TEXT, 0, 1'b0);
      send_item(REQ_TEXT, 0, 1'b0);
      send_item(REQ_TEXT, 1, 1'b0);
      send_item(REQ_TEXT, 2, 1'b0);
      send_item(REQ_READ, 0, 1'b0);
      send_item(REQ_READ, 0, 1'b0);
      send_item(REQ_READ, 0, 1'b0);
      send_pattern('{2});
      send_item(REQ_TEXT, 25, 1'b0);
      send_item(REQ_TEXT, 2, 1'b0);
      send_item(REQ_TEXT, 1, 1'b1);
      send_item(REQ_READ, 0, 1'b0);
      send_item(REQ_READ, 0, 1'b0);
   endtask

   // Mostly well-formed patterns and text over a small alphabet so matches
   // are frequent, with reads and some noise mixed in.
   task automatic test_random(input int count);
      int unsigned pick, n;
      int unsigned letters[$];
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            letters.delete();
            n = $urandom_range(1, 3);
            repeat (n) letters = {letters, $urandom_range(0, 2)};
            if ($urandom_range(0, 5) == 0) begin
               foreach (letters[j]) send_item(REQ_PATTERN, letters[j], 1'b0);
            end else begin
               send_pattern(letters);
            end
         end else if (pick < 55) begin
            send_item(REQ_TEXT, ($urandom_range(0, 15) == 0) ? $urandom_range(0, 31)
                      : $urandom_range(0, 3), $urandom_range(0, 1));
         end else if (pick < 95) begin
            send_item(REQ_READ, $urandom_range(0, 31), $urandom_range(0, 1));
         end else begin
            send_item(REQ_NONE, $urandom_range(0, 31), $urandom_range(0, 1));
         end
      end
   endtask

   // The receiver holds off while requests keep coming.
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      for (int i = 0; i < 40; i++)
         send_item((i % 2) ? REQ_READ : REQ_TEXT, $urandom_range(0, 3), 1'b0);
   endtask

   // One long pattern grows the trie until it is full.
   task automatic test_trie_full();
      for (int i = 0; i < MAX_NODES + 20; i++) send_item(REQ_PATTERN, 23, 1'b0);
      send_item(REQ_PATTERN, 23, 1'b1);
      send_item(REQ_TEXT, 0, 1'b0);
      repeat (3) send_item(REQ_READ, 0, 1'b0);
   endtask

   initial begin
      for (int i = 0; i < SLOT_N; i++) begin
         sh_goto[i] = '0;
         sh_edge[i] = 1'b0;
      end
      for (int i = 0; i < MAX_NODES; i++) begin
         sh_fail[i] = '0;
         sh_mlen[i] = '0;
      end
      sh_nodes = 0;
      sh_cursor = 0;
      sh_depth = 0;
      sh_top = 0;
      sh_rd = 0;
      sh_dirty = 1'b0;
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= REQ_PATTERN;
      req_ch.symbol      <= '0;
      req_ch.pattern_end <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(500);
      test_backpressure();
      calm = 1'b1;
      test_random(150);
      test_trie_full();
      req_ch.valid <= 1'b0;

      while (awaited_resps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end
endmodule
